>>> rtl/core/stp_pkg.sv
// Shared types, codes and helper functions for the source text prefilter.
// No dependencies; every other file of the block but stp_ram imports this package.
package stp_pkg;

  localparam int unsigned MAX_TEXT_LEN_DEF = 1048576;

  localparam int CNT_W   = 21;
  localparam int SIZE_W  = 22;
  localparam int ENTRY_W = 10;
  localparam int TBL_DEPTH = 256;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_BYTE = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  localparam logic [1:0] CLS_ACCEPT = 2'd0;
  localparam logic [1:0] CLS_FORBID = 2'd1;
  localparam logic [1:0] CLS_IGNORE = 2'd2;
  localparam logic [1:0] CLS_SUBST  = 2'd3;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        out_char;
    logic [CNT_W-1:0]  error_line;
    logic [CNT_W-1:0]  error_column;
    logic [CNT_W-1:0]  line_total;
    logic [SIZE_W-1:0] out_size;
    logic [CNT_W-1:0]  ignored_total;
    logic              last;
  } res_t;

  function automatic logic is_separator(input logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h2c) || (c == 8'h3d) ||
           (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2f) || (c == 8'h2a) ||
           (c == 8'h7b) || (c == 8'h7d) || (c == 8'h3b) || (c == 8'h27);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] cap);
    return (v < cap) ? v + CNT_W'(1) : cap;
  endfunction

  function automatic logic [SIZE_W-1:0] sat_inc_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] cap);
    return (v < cap) ? v + SIZE_W'(1) : cap;
  endfunction

endpackage

>>> rtl/core/stp_ifs.sv
// Valid/ready channel interfaces for the source text prefilter.
// Depends on stp_pkg for field widths.
interface stp_in_if
  import stp_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] byte_value;
  logic [1:0] entry_class;
  logic [7:0] entry_subst;

  modport source (output valid, func, byte_value, entry_class, entry_subst, input ready);
  modport sink   (input valid, func, byte_value, entry_class, entry_subst, output ready);
endinterface

interface stp_out_if
  import stp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        out_char;
  logic [CNT_W-1:0]  error_line;
  logic [CNT_W-1:0]  error_column;
  logic [CNT_W-1:0]  line_total;
  logic [SIZE_W-1:0] out_size;
  logic [CNT_W-1:0]  ignored_total;
  logic              last;

  modport source (output valid, kind, out_char, error_line, error_column, line_total,
                  out_size, ignored_total, last, input ready);
  modport sink   (input valid, kind, out_char, error_line, error_column, line_total,
                  out_size, ignored_total, last, output ready);
endinterface

>>> rtl/core/stp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/stp_engine.sv
// Per-character processing: line/column tracking, classification outcome,
// separator padding, blank collapse, counters and the result register.
// Depends on stp_pkg.
module stp_engine
  import stp_pkg::*;
#(
  parameter int unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  item_t              item,
  input  logic [ENTRY_W-1:0] entry,
  output logic               item_done,
  input  logic               out_ready,
  output logic               out_valid,
  output res_t               out_res
);

  localparam longint unsigned CNT_CAP_L =
    (longint'(MAX_TEXT_LEN) < 64'd2097151) ? longint'(MAX_TEXT_LEN) : 64'd2097151;
  localparam longint unsigned SIZE_CAP_L =
    (longint'(MAX_TEXT_LEN) * 3 + 1 < 64'd4194303) ? longint'(MAX_TEXT_LEN) * 3 + 1
                                                   : 64'd4194303;
  localparam logic [CNT_W-1:0]  CNT_CAP  = CNT_W'(CNT_CAP_L);
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SIZE_CAP_L);

  logic [CNT_W-1:0]  raw_line_r, raw_line_nxt;
  logic [CNT_W-1:0]  column_r, column_nxt;
  logic [CNT_W-1:0]  ignored_r, ignored_nxt;
  logic [CNT_W-1:0]  out_lines_r, out_lines_nxt;
  logic [SIZE_W-1:0] emitted_r, emitted_nxt;
  logic              prev_blank_r, prev_blank_nxt;
  logic              halted_r, halted_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  logic [1:0]       cls;
  logic [7:0]       c_eff;
  logic             sep;
  logic [7:0]       ph_char;
  logic             blank;
  logic             is_byte, keep, is_err, is_end;
  logic             emit_ch, emit, final_ph, out_free, adv;
  logic             is_nl;
  logic [CNT_W-1:0] line_eff, col_base;

  always_comb begin
    cls      = entry[9:8];
    c_eff    = (cls == CLS_SUBST) ? entry[7:0] : item.byte_value;
    sep      = is_separator(c_eff);
    ph_char  = (sep && phase_r != 2'd1) ? CHAR_SPACE : c_eff;
    blank    = (ph_char == CHAR_SPACE) || (ph_char == CHAR_NUL);
    is_byte  = item_valid && (item.func == FUNC_BYTE) && !halted_r;
    keep     = is_byte && ((cls == CLS_ACCEPT) || (cls == CLS_SUBST));
    is_err   = is_byte && (cls == CLS_FORBID);
    is_end   = item_valid && (item.func == FUNC_END) && !halted_r;
    emit_ch  = keep && !(blank && prev_blank_r);
    emit     = emit_ch || is_err || is_end;
    final_ph = !sep || (phase_r == 2'd2);
    out_free = !out_valid_r || out_ready;
    adv      = item_valid && (!emit || out_free);
    item_done = adv && (!keep || final_ph);
    is_nl    = (item.byte_value == CHAR_NL);
    line_eff = is_nl ? sat_inc_cnt(raw_line_r, CNT_CAP) : raw_line_r;
    col_base = is_nl ? '0 : column_r;
  end

  always_comb begin
    raw_line_nxt   = raw_line_r;
    column_nxt     = column_r;
    ignored_nxt    = ignored_r;
    out_lines_nxt  = out_lines_r;
    emitted_nxt    = emitted_r;
    prev_blank_nxt = prev_blank_r;
    halted_nxt     = halted_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_res_nxt    = out_res_r;

    if (adv) begin
      phase_nxt = item_done ? 2'd0 : phase_r + 2'd1;

      // raw position and class effects happen once, on the first phase
      if (is_byte && phase_r == 2'd0) begin
        raw_line_nxt = line_eff;
        column_nxt   = col_base;
        case (cls)
          CLS_ACCEPT: column_nxt  = sat_inc_cnt(col_base, CNT_CAP);
          CLS_FORBID: halted_nxt  = 1'b1;
          CLS_IGNORE: ignored_nxt = sat_inc_cnt(ignored_r, CNT_CAP);
          default: ;
        endcase
      end

      if (keep) begin
        prev_blank_nxt = blank;
        if (emit_ch) begin
          emitted_nxt = sat_inc_size(emitted_r, SIZE_CAP);
        end
        if ((ph_char == CHAR_NL) || (ph_char == CHAR_NUL)) begin
          out_lines_nxt = sat_inc_cnt(out_lines_r, CNT_CAP);
        end
      end

      if (emit) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = '0;
        out_res_nxt.last = 1'b1;
        if (emit_ch) begin
          out_res_nxt.kind     = KIND_CHAR;
          out_res_nxt.out_char = ph_char;
          out_res_nxt.last     = final_ph;
        end else if (is_err) begin
          out_res_nxt.kind         = KIND_ERROR;
          out_res_nxt.error_line   = line_eff;
          out_res_nxt.error_column = col_base;
        end else begin
          out_res_nxt.kind          = KIND_END;
          out_res_nxt.line_total    = sat_inc_cnt(out_lines_r, CNT_CAP);
          out_res_nxt.out_size      = prev_blank_r ? emitted_r
                                                   : sat_inc_size(emitted_r, SIZE_CAP);
          out_res_nxt.ignored_total = ignored_r;
        end
      end

      if (is_end) begin
        raw_line_nxt   = CNT_W'(1);
        column_nxt     = '0;
        ignored_nxt    = '0;
        out_lines_nxt  = '0;
        emitted_nxt    = '0;
        prev_blank_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_line_r   <= CNT_W'(1);
      column_r     <= '0;
      ignored_r    <= '0;
      out_lines_r  <= '0;
      emitted_r    <= '0;
      prev_blank_r <= 1'b0;
      halted_r     <= 1'b0;
      phase_r      <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      raw_line_r   <= raw_line_nxt;
      column_r     <= column_nxt;
      ignored_r    <= ignored_nxt;
      out_lines_r  <= out_lines_nxt;
      emitted_r    <= emitted_nxt;
      prev_blank_r <= prev_blank_nxt;
      halted_r     <= halted_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // padding phases only ever run for a kept separator
  a_phase_sep: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != 2'd0) |-> (keep && sep))
    else $error("padding phase without a kept separator");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !(adv && emit))
    else $error("result produced while halted");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_end) |=> (emitted_r == '0) && (out_lines_r == '0) &&
                        (raw_line_r == CNT_W'(1)) && !prev_blank_r)
    else $error("counters not cleared after end item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(adv && emit))
    else $error("result register overwritten while held");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    raw_line_r != '0)
    else $error("raw line counter reached zero");

endmodule

>>> rtl/core/source_text_prefilter.sv
// Top level of the source text prefilter: input stage, class table RAM and
// the processing engine. Depends on stp_pkg, stp_ifs, stp_ram, stp_engine.
// Path: an item and its table entry are registered in the input stage, and
// its result is then registered in the engine's single result register.
// Throughput: one item per cycle while the result register is free; a kept
// separator holds the engine for its padding phases (space, separator, space).
// Reset: synchronous, active low; clears counters, halt and handshake state.
// The class table is not cleared and must be loaded before use.
module source_text_prefilter
  import stp_pkg::*;
#(
  parameter int unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  stp_in_if.sink   in_ch,
  stp_out_if.source out_ch
);

  logic               s1_valid_r, s1_valid_nxt;
  item_t              s1_item_r;
  logic               in_xfer;
  logic               item_done;
  logic [ENTRY_W-1:0] entry;
  logic               tbl_we;
  res_t               res;

  assign in_ch.ready = !s1_valid_r || item_done;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign tbl_we      = in_xfer && (in_ch.func == FUNC_LOAD);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (item_done) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_xfer) begin
      s1_item_r.func       <= in_ch.func;
      s1_item_r.byte_value <= in_ch.byte_value;
    end
  end

  stp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(in_ch.byte_value),
    .wdata({in_ch.entry_class, in_ch.entry_subst}),
    .re   (in_xfer),
    .raddr(in_ch.byte_value),
    .rdata(entry)
  );

  stp_engine #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(s1_valid_r),
    .item      (s1_item_r),
    .entry     (entry),
    .item_done (item_done),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (res)
  );

  assign out_ch.kind          = res.kind;
  assign out_ch.out_char      = res.out_char;
  assign out_ch.error_line    = res.error_line;
  assign out_ch.error_column  = res.error_column;
  assign out_ch.line_total    = res.line_total;
  assign out_ch.out_size      = res.out_size;
  assign out_ch.ignored_total = res.ignored_total;
  assign out_ch.last          = res.last;

endmodule

>>> tb/source_text_prefilter_tb.sv
// Testbench for source_text_prefilter: drives table loads, source bytes and end items,
// predicts the cleaned text and reports in SV, and checks every result transfer.
// Depends on stp_pkg, stp_ifs and the source_text_prefilter RTL.
module source_text_prefilter_tb;
  import stp_pkg::*;

  localparam int unsigned TXT_MAX = 256;
  localparam logic [CNT_W-1:0]  LINE_CAP = CNT_W'(TXT_MAX);
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(3 * TXT_MAX + 1);
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 20;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [7:0] TAB_CHAR   = 8'h09;  // substituted by a space
  localparam logic [7:0] SEMI_ALIAS = "A";    // substituted by a separator
  localparam logic [7:0] DROP_CHAR  = 8'h7f;  // ignored
  localparam logic [7:0] NUL_ALIAS  = "~";    // substituted by a zero byte
  localparam logic [7:0] NL_ALIAS   = 8'hb0;  // substituted by a newline
  localparam logic [7:0] BAD_CHAR   = 8'hfe;  // forbidden, last test only

  logic clk;
  logic rst_n;

  stp_in_if  in_ch();
  stp_out_if out_ch();

  source_text_prefilter #(.MAX_TEXT_LEN(TXT_MAX)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predictor state
  logic [1:0]        cls_tbl [TBL_DEPTH];
  logic [7:0]        sub_tbl [TBL_DEPTH];
  logic [CNT_W-1:0]  raw_line;
  logic [CNT_W-1:0]  col_cnt;
  logic [CNT_W-1:0]  ign_cnt;
  logic [CNT_W-1:0]  line_cnt;
  logic [SIZE_W-1:0] char_cnt;
  logic              blank_run;
  logic              halted;

  res_t clean_text_q[$];
  int   n_errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] v);
    return (v < LINE_CAP) ? v + 1'b1 : LINE_CAP;
  endfunction

  function automatic logic [SIZE_W-1:0] size_up(input logic [SIZE_W-1:0] v);
    return (v < SIZE_CAP) ? v + 1'b1 : SIZE_CAP;
  endfunction

  function automatic logic is_pad_sep(input logic [7:0] c);
    case (c)
      "(", ")", ",", "=", "+", "-", "/", "*", "{", "}", ";", "'": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_char(input logic [7:0] c);
    res_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.out_char = c;
    clean_text_q.push_back(r);
    char_cnt = size_up(char_cnt);
  endfunction

  function automatic void collapse_char(input logic [7:0] c);
    if (c == CHAR_SPACE || c == CHAR_NUL) begin
      if (!blank_run) push_char(c);
      blank_run = 1'b1;
    end else begin
      push_char(c);
      blank_run = 1'b0;
    end
    if (c == CHAR_NL || c == CHAR_NUL) line_cnt = cnt_up(line_cnt);
  endfunction

  function automatic void keep_char(input logic [7:0] c);
    if (is_pad_sep(c)) begin
      collapse_char(CHAR_SPACE);
      collapse_char(c);
      collapse_char(CHAR_SPACE);
    end else begin
      collapse_char(c);
    end
  endfunction

  function automatic void clear_text();
    raw_line  = CNT_W'(1);
    col_cnt   = '0;
    ign_cnt   = '0;
    line_cnt  = '0;
    char_cnt  = '0;
    blank_run = 1'b0;
  endfunction

  // expected results of one accepted item
  function automatic void clean_item(input logic [1:0] func, input logic [7:0] b,
                                     input logic [1:0] cls, input logic [7:0] sub);
    int   base;
    res_t r;
    if (halted) return;
    base = clean_text_q.size();
    case (func)
      FUNC_LOAD: begin
        cls_tbl[b] = cls;
        sub_tbl[b] = sub;
      end
      FUNC_BYTE: begin
        if (b == CHAR_NL) begin
          col_cnt  = '0;
          raw_line = cnt_up(raw_line);
        end
        case (cls_tbl[b])
          CLS_ACCEPT: begin
            col_cnt = cnt_up(col_cnt);
            keep_char(b);
          end
          CLS_FORBID: begin
            r = '0;
            r.kind = KIND_ERROR;
            r.error_line = raw_line;
            r.error_column = col_cnt;
            clean_text_q.push_back(r);
            halted = 1'b1;
          end
          CLS_IGNORE: ign_cnt = cnt_up(ign_cnt);
          default: keep_char(sub_tbl[b]);
        endcase
      end
      FUNC_END: begin
        r = '0;
        r.kind = KIND_END;
        r.line_total = cnt_up(line_cnt);
        r.out_size = blank_run ? char_cnt : size_up(char_cnt);
        r.ignored_total = ign_cnt;
        clean_text_q.push_back(r);
        clear_text();
      end
      default: ;
    endcase
    if (clean_text_q.size() > base) begin
      r = clean_text_q.pop_back();
      r.last = 1'b1;
      clean_text_q.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (clean_text_q.size() == 0) begin
      $error("unexpected result transfer: kind %0d char %0h", out_ch.kind, out_ch.out_char);
      n_errors++;
      return;
    end
    want = clean_text_q.pop_front();
    check_field("kind", want.kind, out_ch.kind);
    check_field("out_char", want.out_char, out_ch.out_char);
    check_field("error_line", want.error_line, out_ch.error_line);
    check_field("error_column", want.error_column, out_ch.error_column);
    check_field("line_total", want.line_total, out_ch.line_total);
    check_field("out_size", want.out_size, out_ch.out_size);
    check_field("ignored_total", want.ignored_total, out_ch.ignored_total);
    check_field("last", want.last, out_ch.last);
  endfunction

  // input transfers are predicted before output transfers are checked
  always @(posedge clk) begin : monitor_blk
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        clean_item(in_ch.func, in_ch.byte_value, in_ch.entry_class, in_ch.entry_subst);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  task automatic set_pacing(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  task automatic send_item(input logic [1:0] func, input logic [7:0] b,
                           input logic [1:0] cls, input logic [7:0] sub);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func;
    in_ch.byte_value  <= b;
    in_ch.entry_class <= cls;
    in_ch.entry_subst <= sub;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [1:0] cls,
                            input logic [7:0] sub);
    send_item(FUNC_LOAD, idx, cls, sub);
  endtask

  // unused fields carry noise
  task automatic send_byte(input logic [7:0] b);
    send_item(FUNC_BYTE, b, 2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  task automatic end_text();
    send_item(FUNC_END, 8'($urandom_range(255)), 2'($urandom_range(3)),
              8'($urandom_range(255)));
  endtask

  task automatic send_noop();
    send_item(FUNC_NONE, 8'($urandom_range(255)), 2'($urandom_range(3)),
              8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (clean_text_q.size() != 0) @(negedge clk);
  endtask

  // only the bytes that the tests send get an entry
  task automatic load_base_table();
    for (int i = 0; i < TBL_DEPTH; i++) begin
      case (8'(i))
        TAB_CHAR:   load_entry(8'(i), CLS_SUBST, CHAR_SPACE);
        SEMI_ALIAS: load_entry(8'(i), CLS_SUBST, ";");
        NUL_ALIAS:  load_entry(8'(i), CLS_SUBST, CHAR_NUL);
        NL_ALIAS:   load_entry(8'(i), CLS_SUBST, CHAR_NL);
        DROP_CHAR, "#": load_entry(8'(i), CLS_IGNORE, 8'($urandom_range(255)));
        CHAR_NUL, CHAR_NL, CHAR_SPACE, "a", "b", 8'hff:
          load_entry(8'(i), CLS_ACCEPT, 8'($urandom_range(255)));
        default: begin
          if (is_pad_sep(8'(i))) load_entry(8'(i), CLS_ACCEPT, 8'($urandom_range(255)));
        end
      endcase
    end
  endtask

  task automatic test_directed_text();
    load_entry(CHAR_NL, CLS_IGNORE, 8'hff);   // raw line still counts
    send_byte(CHAR_NL);
    load_entry(CHAR_NL, CLS_SUBST, "x");
    send_byte(CHAR_NL);
    load_entry(CHAR_NL, CLS_ACCEPT, 8'h00);
    send_byte("a");
    send_byte(CHAR_SPACE);
    send_byte(CHAR_SPACE);
    send_byte(CHAR_NUL);
    send_byte(CHAR_NUL);
    send_byte("(");
    send_byte(")");
    send_byte(CHAR_NL);
    send_byte(8'hff);
    send_byte(TAB_CHAR);
    send_byte(NL_ALIAS);
    send_byte(SEMI_ALIAS);
    send_noop();
    send_byte(DROP_CHAR);
    end_text();                               // trailing blank swallows terminator
    end_text();                               // empty text
    send_byte("b");
    end_text();
    wait_drained();
  endtask

  task automatic test_random_text();
    int n;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_pacing(0, 0);
        1: set_pacing(82, 0);
        2: set_pacing(0, 82);
        default: set_pacing(32, 32);
      endcase
      n = 0;
      while (n < 16) begin
        n++;
        case ($urandom_range(99)) inside
          [0:5]: begin
            case ($urandom_range(2))
              0: load_entry(8'($urandom_range(255)), CLS_ACCEPT, 8'($urandom_range(255)));
              1: load_entry(8'($urandom_range(255)), CLS_IGNORE, 8'($urandom_range(255)));
              default: load_entry(8'($urandom_range(255)), CLS_SUBST,
                                  8'($urandom_range(255)));
            endcase
          end
          [6:11]: end_text();
          [12:13]: begin
            send_noop();
            n--;
          end
          default: begin
            case ($urandom_range(15))
              0: send_byte(CHAR_SPACE);
              1: send_byte(CHAR_NUL);
              2: send_byte(CHAR_NL);
              3: send_byte(TAB_CHAR);
              4: send_byte(SEMI_ALIAS);
              5: send_byte(DROP_CHAR);
              6: send_byte(NUL_ALIAS);
              7: send_byte(NL_ALIAS);
              8, 9, 10: begin
                case ($urandom_range(11))
                  0: send_byte("(");
                  1: send_byte(")");
                  2: send_byte(",");
                  3: send_byte("=");
                  4: send_byte("+");
                  5: send_byte("-");
                  6: send_byte("/");
                  7: send_byte("*");
                  8: send_byte("{");
                  9: send_byte("}");
                  10: send_byte(";");
                  default: send_byte("'");
                endcase
              end
              default: begin
                case ($urandom_range(3))
                  0: send_byte("a");
                  1: send_byte("b");
                  2: send_byte(8'hff);
                  default: send_byte("#");
                endcase
              end
            endcase
          end
        endcase
      end
      wait_drained();
    end
  endtask

  // must run last: nothing but reset leaves the halted state
  task automatic test_forbidden_halt();
    set_pacing(32, 32);
    load_entry(CHAR_NL, CLS_ACCEPT, 8'h00);
    load_entry("a", CLS_ACCEPT, 8'h00);
    load_entry(BAD_CHAR, CLS_FORBID, 8'h00);
    repeat (3) send_byte(CHAR_NL);
    repeat (2) send_byte("a");
    send_byte(BAD_CHAR);
    load_entry("a", CLS_SUBST, ";");
    send_byte("a");
    send_byte(BAD_CHAR);
    end_text();
    send_noop();
    wait_drained();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_LOAD;
    in_ch.byte_value  = '0;
    in_ch.entry_class = CLS_ACCEPT;
    in_ch.entry_subst = '0;
    out_ch.ready      = 1'b0;
    halted            = 1'b0;
    clear_text();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    load_base_table();
    test_directed_text();
    test_random_text();
    test_forbidden_halt();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
